[sv/mwf_pkg.sv]
package mwf_pkg;

   localparam int MAX_WINDOW = 7;
   localparam int MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int LINE_ROWS = MAX_WINDOW + 1;
   localparam int LROW_W = $clog2(LINE_ROWS);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int DIM_W = 11;
   localparam int HZ_W = DIM_W + 2;
   localparam int PIX_W = 24;
   localparam int CSR_IDX_W = 2;
   localparam int JOB_DEPTH = 4;
   localparam int JQ_W = $clog2(JOB_DEPTH);
   localparam int RES_DEPTH = 4;
   localparam int RQ_W = $clog2(RES_DEPTH);

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

   localparam logic [1:0] MODE_DILATE = 2'd0;
   localparam logic [1:0] MODE_ERODE = 2'd1;
   localparam logic [1:0] MODE_GRADIENT = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       frame_done;
   } rsp_type;

   typedef struct packed {
      logic                 emit;
      logic                 fetch;
      logic [COL_W-1:0]     addr;
      logic [LINE_ROWS-1:0] lane_mask;
      logic [WIN_W-1:0]     count;
      logic                 last;
   } op_type;

   typedef struct packed {
      logic [2:0][7:0] mx;
      logic [2:0][7:0] mn;
   } column_type;

endpackage

[sv/mwf_ram.sv]
module mwf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mwf_merge.sv]
module mwf_merge import mwf_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  op_type                          op,
   input  logic [LINE_ROWS-1:0][PIX_W-1:0] lane_pixel,
   input  logic [1:0]                      mode,
   output logic                            res_valid,
   output rsp_type                         res
);

   column_type       vert;
   column_type       col_ff [MAX_WINDOW];
   logic             emit_ff;
   logic [WIN_W-1:0] count_ff;
   logic             last_ff;
   logic [2:0][7:0]  hmx;
   logic [2:0][7:0]  hmn;
   logic [2:0][7:0]  val;

   always_comb begin
      logic [7:0] v;
      for (int k = 0; k < 3; k++) begin
         vert.mx[k] = 8'd0;
         vert.mn[k] = 8'd255;
         for (int s = 0; s < LINE_ROWS; s++) begin
            v = lane_pixel[s][8*k +: 8];
            if (op.lane_mask[s]) begin
               if (v > vert.mx[k]) vert.mx[k] = v;
               if (v < vert.mn[k]) vert.mn[k] = v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op.fetch) begin
         col_ff[0] <= vert;
         for (int i = 1; i < MAX_WINDOW; i++) begin
            col_ff[i] <= col_ff[i-1];
         end
      end
      count_ff <= op.count;
      last_ff <= op.last;
      if (reset) begin
         emit_ff <= 1'b0;
      end else begin
         emit_ff <= op.emit;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hmx[k] = 8'd0;
         hmn[k] = 8'd255;
         for (int i = 0; i < MAX_WINDOW; i++) begin
            if (WIN_W'(i) < count_ff) begin
               if (col_ff[i].mx[k] > hmx[k]) hmx[k] = col_ff[i].mx[k];
               if (col_ff[i].mn[k] < hmn[k]) hmn[k] = col_ff[i].mn[k];
            end
         end
         case (mode)
            MODE_DILATE: val[k] = hmx[k];
            MODE_ERODE: val[k] = hmn[k];
            default: val[k] = hmx[k] - hmn[k];
         endcase
      end
   end

   assign res_valid = emit_ff;
   assign res.out_blue = val[0];
   assign res.out_green = val[1];
   assign res.out_red = val[2];
   assign res.frame_done = last_ff;

endmodule

[sv/rgb_morphology_window_filter.sv]
// Square-window dilate, erode or gradient filter over an RGB pixel stream.
// Requests arrive on req_valid/req_ready: a pixel (cmd 0) in raster order or
// a flush tick (cmd 1) sent after the frame's last pixel. Each request yields
// at most one result on rsp_valid/rsp_ready, in raster order of the centers;
// frame_done marks the result of the frame's last center.
// Configuration is written through csr_write/csr_index/csr_data while the
// block is idle; any write restarts the frame counters.
// Eight line RAMs, one per ring row, are read at one column per cycle while
// a center waits and the result queue has room; the lanes are merged into a
// column minimum and maximum, and a shift line of columns gives the window result.
// A result passes through the job queue, the op register and line RAM read,
// the merge shift line and a 4-entry result queue. Throughput is one request
// per cycle while req_ready is high; the first center of each output row
// fetches its leading columns before its result is emitted. The first request
// of a new frame waits until the previous frame's centers have been fetched.
// When rsp_ready is low, the queue fills and req_ready drops; nothing is lost.
// Reset restores the default configuration and empties all queues; the line
// RAMs are not cleared.
module rgb_morphology_window_filter import mwf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } job_type;

   logic [2:0]       win_ff;
   logic [1:0]       mode_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [DIM_W-1:0] in_col_ff, in_col_in;
   logic [DIM_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff;
   logic [ROW_W-1:0] out_row_ff;

   job_type          job_q_ff [JOB_DEPTH];
   logic [JQ_W-1:0]  jhead_ff, jtail_ff;
   logic [JQ_W:0]    jcount_ff;
   rsp_type          res_q_ff [RES_DEPTH];
   logic [RQ_W-1:0]  rhead_ff, rtail_ff;
   logic [RQ_W:0]    rcount_ff;
   logic [COL_W-1:0] fcol_ff;
   op_type           opb_ff, op;

   logic [WIN_W-1:0] n_eff, back, ahead;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic             accept, pix_ok, job_ready, frame_end, hazard_ok, frame_start;
   logic [DIM_W-1:0] last_r, last_c;
   job_type          hj;
   logic             issue, credit_ok, col_zero, pop;
   logic [DIM_W-1:0] hc1, c0, r0, r1, ahead_col, ahead_row;
   logic [WIN_W-1:0] span;
   logic [LINE_ROWS-1:0][PIX_W-1:0] lane_pixel;
   logic             res_valid, rsp_pop;
   rsp_type          res;

   always_comb begin
      if (win_ff == 3'd0) n_eff = WIN_W'(1);
      else if (32'(win_ff) > MAX_WINDOW) n_eff = WIN_W'(MAX_WINDOW);
      else n_eff = WIN_W'(win_ff);
      back = n_eff >> 1;
      ahead = n_eff - WIN_W'(1) - back;
      if (width_ff == '0) w_eff = DIM_W'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = DIM_W'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
      else h_eff = height_ff;
   end

   // Request side: position counters and readiness of the next center.
   assign hj = job_q_ff[jhead_ff];
   assign frame_start = (in_row_ff == '0) && (in_col_ff == '0);
   assign hazard_ok = (jcount_ff == '0) || (!frame_start &&
      (HZ_W'(in_row_ff) + HZ_W'(back) < HZ_W'(hj.row) + HZ_W'(LINE_ROWS)));
   assign req_ready = (32'(jcount_ff) < JOB_DEPTH) && hazard_ok;
   assign accept = req_valid && req_ready;
   assign pix_ok = (req_data.cmd == CMD_PIXEL) && (in_row_ff < h_eff) && (in_col_ff < w_eff);

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (pix_ok) begin
         in_col_in = in_col_ff + DIM_W'(1);
         if (in_col_in >= w_eff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + DIM_W'(1);
         end
      end
      last_r = DIM_W'(out_row_ff) + DIM_W'(ahead);
      if (last_r > h_eff - DIM_W'(1)) last_r = h_eff - DIM_W'(1);
      last_c = DIM_W'(out_col_ff) + DIM_W'(ahead);
      if (last_c > w_eff - DIM_W'(1)) last_c = w_eff - DIM_W'(1);
      job_ready = (last_r < in_row_in) || ((last_r == in_row_in) && (last_c < in_col_in));
      frame_end = (DIM_W'(out_row_ff) >= h_eff - DIM_W'(1)) &&
                  (DIM_W'(out_col_ff) >= w_eff - DIM_W'(1));
   end

   // Fetch sequencer: one column read per cycle for the head center while the result queue has room.
   assign credit_ok = (32'(rcount_ff) + 32'(opb_ff.emit) + 32'(res_valid) + 1) <= RES_DEPTH;
   assign issue = (jcount_ff != '0) && credit_ok;
   assign col_zero = (hj.col == '0);

   always_comb begin
      ahead_col = DIM_W'(hj.col) + DIM_W'(ahead);
      hc1 = (ahead_col > w_eff - DIM_W'(1)) ? w_eff - DIM_W'(1) : ahead_col;
      c0 = (DIM_W'(hj.col) >= DIM_W'(back)) ? DIM_W'(hj.col) - DIM_W'(back) : '0;
      ahead_row = DIM_W'(hj.row) + DIM_W'(ahead);
      r1 = (ahead_row > h_eff - DIM_W'(1)) ? h_eff - DIM_W'(1) : ahead_row;
      r0 = (DIM_W'(hj.row) >= DIM_W'(back)) ? DIM_W'(hj.row) - DIM_W'(back) : '0;
      span = WIN_W'(r1 - r0);
      op = '0;
      op.last = hj.last;
      op.count = WIN_W'(hc1 - c0 + DIM_W'(1));
      for (int s = 0; s < LINE_ROWS; s++) begin
         op.lane_mask[s] = ((LROW_W'(s) - r0[LROW_W-1:0]) <= LROW_W'(span));
      end
      if (col_zero) begin
         op.addr = fcol_ff;
         op.fetch = issue;
         op.emit = issue && (DIM_W'(fcol_ff) == hc1);
      end else begin
         op.addr = hc1[COL_W-1:0];
         op.fetch = issue && (ahead_col <= w_eff - DIM_W'(1));
         op.emit = issue;
      end
      pop = op.emit;
   end

   for (genvar g = 0; g < LINE_ROWS; g++) begin : g_lane
      mwf_ram #(
         .WIDTH(PIX_W),
         .DEPTH(MAX_WIDTH)
      ) u_line (
         .clock  (clock),
         .wr_en  (accept && pix_ok && (in_row_ff[LROW_W-1:0] == LROW_W'(g))),
         .wr_addr(in_col_ff[COL_W-1:0]),
         .wr_data({req_data.in_red, req_data.in_green, req_data.in_blue}),
         .rd_addr(op.addr),
         .rd_data(lane_pixel[g])
      );
   end

   mwf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .op        (opb_ff),
      .lane_pixel(lane_pixel),
      .mode      (mode_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid = (rcount_ff != '0);
   assign rsp_data = res_q_ff[rhead_ff];
   assign rsp_pop = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (accept && job_ready) begin
         job_q_ff[jtail_ff] <= '{row: out_row_ff, col: out_col_ff, last: frame_end};
      end
      if (res_valid) begin
         res_q_ff[rtail_ff] <= res;
      end
      if (reset) begin
         win_ff <= 3'd3;
         mode_ff <= MODE_DILATE;
         width_ff <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         jhead_ff <= '0;
         jtail_ff <= '0;
         jcount_ff <= '0;
         rhead_ff <= '0;
         rtail_ff <= '0;
         rcount_ff <= '0;
         fcol_ff <= '0;
         opb_ff <= '0;
      end else begin
         opb_ff <= op;
         if (csr_write) begin
            case (csr_index)
               REG_WINDOW_SIZE: win_ff <= csr_data[2:0];
               REG_FILTER_MODE: mode_ff <= csr_data[1:0];
               REG_IMAGE_WIDTH: width_ff <= csr_data;
               REG_IMAGE_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
            in_col_ff <= '0;
            in_row_ff <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (accept) begin
            in_col_ff <= in_col_in;
            in_row_ff <= in_row_in;
            if (job_ready) begin
               if (frame_end) begin
                  in_col_ff <= '0;
                  in_row_ff <= '0;
                  out_col_ff <= '0;
                  out_row_ff <= '0;
               end else if (DIM_W'(out_col_ff) + DIM_W'(1) >= w_eff) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + ROW_W'(1);
               end else begin
                  out_col_ff <= out_col_ff + COL_W'(1);
               end
            end
         end
         if (issue && col_zero) begin
            fcol_ff <= op.emit ? '0 : fcol_ff + COL_W'(1);
         end
         if (accept && job_ready) begin
            jtail_ff <= jtail_ff + JQ_W'(1);
         end
         if (pop) begin
            jhead_ff <= jhead_ff + JQ_W'(1);
         end
         jcount_ff <= jcount_ff + (JQ_W+1)'(accept && job_ready) - (JQ_W+1)'(pop);
         if (res_valid) begin
            rtail_ff <= rtail_ff + RQ_W'(1);
         end
         if (rsp_pop) begin
            rhead_ff <= rhead_ff + RQ_W'(1);
         end
         rcount_ff <= rcount_ff + (RQ_W+1)'(res_valid) - (RQ_W+1)'(rsp_pop);
      end
   end

endmodule
